>>> design/utf8g_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utf8g_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 6;

  localparam logic [CfgIdxW-1:0] CfgCellWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCellHeight = 1'b1;

  localparam logic [5:0] CellWidthReset  = 6'd9;
  localparam logic [5:0] CellHeightReset = 6'd18;

  localparam logic [31:0] AsciiLo  = 32'd32;
  localparam logic [31:0] AsciiHi  = 32'd126;
  localparam logic [31:0] HangulLo = 32'd44032;
  localparam logic [31:0] HangulHi = 32'd55203;
  localparam logic [31:0] JamoLo   = 32'd12593;
  localparam logic [31:0] JamoHi   = 32'd12643;

  localparam logic [3:0] UnknownCol = 4'd15;
  localparam logic [2:0] UnknownRow = 3'd5;

  typedef enum logic [1:0] {
    ClassAscii   = 2'd0,
    ClassKorean  = 2'd1,
    ClassUnknown = 2'd2
  } char_class_e;

  typedef struct packed {
    logic [31:0] code_point;
    char_class_e char_class;
    logic [9:0]  glyph_x;
    logic [8:0]  glyph_y;
  } glyph_t;

endpackage

`default_nettype wire

>>> design/utf8g_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface utf8g_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

>>> design/utf8g_glyph_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface utf8g_glyph_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_point;
  logic [1:0]  char_class;
  logic [9:0]  glyph_x;
  logic [8:0]  glyph_y;

  modport source (
    output valid, output code_point, output char_class, output glyph_x, output glyph_y,
    input ready
  );
  modport sink (
    input valid, input code_point, input char_class, input glyph_x, input glyph_y,
    output ready
  );
endinterface

`default_nettype wire

>>> design/utf8g_classify.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8g_classify (
  input  logic [31:0]       cp_i,
  input  logic [5:0]        cell_w_i,
  input  logic [5:0]        cell_h_i,
  output utf8g_pkg::glyph_t glyph_o
);

  logic       is_ascii;
  logic       is_korean;
  logic [6:0] code;
  logic [3:0] col;
  logic [2:0] row;

  assign is_ascii  = (cp_i >= utf8g_pkg::AsciiLo) && (cp_i <= utf8g_pkg::AsciiHi);
  assign is_korean = ((cp_i >= utf8g_pkg::HangulLo) && (cp_i <= utf8g_pkg::HangulHi)) ||
                     ((cp_i >= utf8g_pkg::JamoLo) && (cp_i <= utf8g_pkg::JamoHi));
  assign code      = cp_i[6:0] - utf8g_pkg::AsciiLo[6:0];

  always_comb begin
    col = utf8g_pkg::UnknownCol;
    row = utf8g_pkg::UnknownRow;
    glyph_o.code_point = cp_i;
    glyph_o.char_class = utf8g_pkg::ClassUnknown;
    if (is_ascii) begin
      col = code[3:0];
      row = code[6:4];
      glyph_o.char_class = utf8g_pkg::ClassAscii;
    end else if (is_korean) begin
      col = 4'd0;
      row = 3'd0;
      glyph_o.char_class = utf8g_pkg::ClassKorean;
    end
    glyph_o.glyph_x = {6'd0, col} * {4'd0, cell_w_i};
    glyph_o.glyph_y = {6'd0, row} * {3'd0, cell_h_i};
  end

endmodule

`default_nettype wire

>>> design/utf8_decode_glyph_classify.sv
// UTF-8 decoder with glyph classification.
// in_byte (valid/ready) carries one text byte per item. A lead byte with n
// leading ones opens a sequence of n-1 continuation bytes; other bytes finish
// a character at once. Each finished code point leaves on out_glyph as one
// item with its class (ASCII, Korean, unknown) and atlas pixel offsets.
// Bytes that do not finish a character produce no item.
// Path: a finishing byte is held in the decode register, then goes through
// classify/multiply into the output register.
// Throughput: one byte per cycle; in_byte.ready drops only while both the
// decode register and the output register hold items and out_glyph is stalled.
// Configuration: cfg_we_i writes cell_width (index 0) or cell_height (index 1),
// low six bits; write only while the block is idle.
// Reset: empties both registers, clears the decode state, and sets cell
// width 9 and height 18.
`timescale 1ns / 1ps
`default_nettype none

module utf8_decode_glyph_classify (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [utf8g_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [utf8g_pkg::CfgDataW-1:0]     cfg_data_i,
  utf8g_byte_if.sink                         in_byte,
  utf8g_glyph_if.source                      out_glyph
);

  logic [5:0]  cell_w_q, cell_h_q;
  logic [2:0]  rem_q, rem_d;
  logic [31:0] pv_q, pv_d;
  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_cp_q, s1_cp_d;
  logic        out_valid_q;
  utf8g_pkg::glyph_t out_q, glyph;

  logic        out_adv, s1_adv, in_acc;
  logic [7:0]  b;
  logic [3:0]  ones;
  logic        run;
  logic [2:0]  follow;
  logic [5:0]  lead_mask;
  logic        emit;
  logic [31:0] emit_cp;

  assign out_adv = !out_valid_q || out_glyph.ready;
  assign s1_adv  = !s1_valid_q || out_adv;
  assign in_byte.ready = s1_adv;
  assign in_acc  = in_byte.valid && s1_adv;
  assign b       = in_byte.text_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_w_q <= utf8g_pkg::CellWidthReset;
      cell_h_q <= utf8g_pkg::CellHeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        utf8g_pkg::CfgCellWidth:  cell_w_q <= cfg_data_i;
        utf8g_pkg::CfgCellHeight: cell_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ones = 4'd0;
    run  = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && b[i]) begin
        ones = ones + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
  end

  assign follow    = 3'(ones - 4'd1);
  assign lead_mask = 6'h3F >> follow;

  always_comb begin
    rem_d   = rem_q;
    pv_d    = pv_q;
    emit    = 1'b0;
    emit_cp = {24'd0, b};
    if (rem_q != 3'd0) begin
      emit_cp = {pv_q[25:0], b[5:0]};
      rem_d   = rem_q - 3'd1;
      if (rem_q == 3'd1) begin
        emit = 1'b1;
        pv_d = 32'd0;
      end else begin
        pv_d = emit_cp;
      end
    end else if (ones == 4'd0) begin
      emit = 1'b1;
    end else if (ones == 4'd1) begin
      emit    = 1'b1;
      emit_cp = {26'd0, b[5:0]};
    end else begin
      pv_d  = {26'd0, b[5:0] & lead_mask};
      rem_d = follow;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_cp_d    = s1_cp_q;
    if (s1_adv) begin
      s1_valid_d = in_acc && emit;
      s1_cp_d    = emit_cp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q      <= 3'd0;
      pv_q       <= 32'd0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        rem_q <= rem_d;
        pv_q  <= pv_d;
      end
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cp_q <= s1_cp_d;
  end

  utf8g_classify u_classify (
    .cp_i     (s1_cp_q),
    .cell_w_i (cell_w_q),
    .cell_h_i (cell_h_q),
    .glyph_o  (glyph)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_q <= glyph;
    end
  end

  assign out_glyph.valid      = out_valid_q;
  assign out_glyph.code_point = out_q.code_point;
  assign out_glyph.char_class = out_q.char_class;
  assign out_glyph.glyph_x    = out_q.glyph_x;
  assign out_glyph.glyph_y    = out_q.glyph_y;

  a_idle_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q == 3'd0) |-> (pv_q == 32'd0))
    else $error("accumulator not clear between characters");

  a_ascii_byte_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (rem_q == 3'd0) && !b[7]) |=> s1_valid_q)
    else $error("single byte character not registered");

  a_korean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.char_class == utf8g_pkg::ClassKorean)) |->
      ((out_q.glyph_x == 10'd0) && (out_q.glyph_y == 9'd0)))
    else $error("korean item with nonzero offset");

  a_mid_seq_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (rem_q > 3'd1)) |=> !s1_valid_q)
    else $error("item emitted mid sequence");

endmodule

`default_nettype wire
